@@ rtl/typed_integer_alu_unit_defines.svh @@
// Assertion macros for the RTL.
`ifndef TYPED_INTEGER_ALU_UNIT_DEFINES_SVH
`define TYPED_INTEGER_ALU_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tia_pkg.sv @@
`default_nettype none
package tia_pkg;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
        OP_SHL, OP_SHR, OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LTEQ, OP_GTEQ
    } t_op;

    localparam logic [3:0] VT_INT  = 4'd8;
    localparam logic [3:0] VT_UINT = 4'd9;
    localparam logic       CFG_INT  = 1'b0;
    localparam logic       CFG_UINT = 1'b1;

    typedef struct packed {
        t_op  op;
        logic w64;
        logic sgn;
        logic tok;
        logic fault;
        logic negq;
        logic negr;
    } t_ctrl;

    function automatic logic [63:0] fit_word(input logic [63:0] v, input logic [1:0] wc,
                                             input logic sgn);
        logic [63:0] r;
        r = v;
        unique case (wc)
            2'd0: r = {{56{sgn & v[7]}}, v[7:0]};
            2'd1: r = {{48{sgn & v[15]}}, v[15:0]};
            2'd2: r = {{32{sgn & v[31]}}, v[31:0]};
            2'd3: r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tia_div_cell.sv @@
`default_nettype none
module tia_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire tia_pkg::t_ctrl i_ctrl,
    input  wire logic [63:0]    i_den,
    input  wire logic [63:0]    i_rem,
    input  wire logic [63:0]    i_quo,
    input  wire logic [63:0]    i_alt,
    output logic                o_valid,
    output tia_pkg::t_ctrl      o_ctrl,
    output logic [63:0]         o_den,
    output logic [63:0]         o_rem,
    output logic [63:0]         o_quo,
    output logic [63:0]         o_alt
);

    logic [64:0] n_shift;
    logic        n_ge;
    logic [64:0] n_diff;

    always_comb begin
        n_shift = {i_rem, i_quo[63]};
        n_ge    = n_shift >= {1'b0, i_den};
        n_diff  = n_shift - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_ctrl <= i_ctrl;
            o_den  <= i_den;
            o_rem  <= n_ge ? n_diff[63:0] : n_shift[63:0];
            o_quo  <= {i_quo[62:0], n_ge};
            o_alt  <= i_alt;
        end
    end

endmodule
`default_nettype wire

@@ rtl/typed_integer_alu_unit.sv @@
// channel | dir | handshake                  | payload
// input   | in  | i_valid / o_ready          | i_kind, i_value_type, i_left_value, i_right_value
// result  | out | o_valid / i_ready          | o_result_value, o_divide_fault
// config  | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word enters per cycle while the pipeline advances.
// The pipeline is the decode stage, the setup stage, the 64-cell restoring divider chain and the output stage.
// The whole pipeline advances when the output register is empty or being taken.
// Synchronous active-low reset clears valid bits and sets both alias widths to 64 bits.
`default_nettype none
`include "typed_integer_alu_unit_defines.svh"
module typed_integer_alu_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [3:0]    i_kind,
    input  wire logic [3:0]    i_value_type,
    input  wire logic [63:0]   i_left_value,
    input  wire logic [63:0]   i_right_value,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_result_value,
    output logic               o_divide_fault,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [1:0]    i_cfg_data
);

    localparam int Cells = 64;

    logic        en;
    logic [1:0]  r_int_w;
    logic [1:0]  r_uint_w;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_w  <= 2'd3;
            r_uint_w <= 2'd3;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == tia_pkg::CFG_INT) r_int_w <= i_cfg_data;
            else r_uint_w <= i_cfg_data;
        end
    end

    // decode stage
    logic [2:0]  n_vt;
    logic        n_tok;
    logic        n_tsgn;
    logic        n_w64;
    logic        n_sgn;
    logic [63:0] n_a;
    logic [63:0] n_b;
    logic [63:0] n_alt;
    logic        n_big;
    logic [5:0]  n_sh;
    logic [63:0] n_flip;
    logic [63:0] n_sa;
    logic [63:0] n_sb;
    tia_pkg::t_op n_op;

    always_comb begin
        n_op  = tia_pkg::t_op'(i_kind);
        n_tok = 1'b1;
        n_vt  = i_value_type[2:0];
        if (i_value_type == tia_pkg::VT_INT) n_vt = {1'b0, r_int_w};
        else if (i_value_type == tia_pkg::VT_UINT) n_vt = {1'b1, r_uint_w};
        else if (i_value_type[3]) n_tok = 1'b0;
        n_tsgn = !n_vt[2];
        n_w64  = n_vt[1:0] == 2'd3;
        n_sgn  = n_tsgn || !n_vt[1];
        n_a    = tia_pkg::fit_word(i_left_value, n_vt[1:0], n_tsgn);
        n_b    = tia_pkg::fit_word(i_right_value, n_vt[1:0], n_tsgn);
        n_big  = n_w64 ? |n_b[63:6] : |n_b[31:5];
        n_sh   = n_w64 ? n_b[5:0] : {1'b0, n_b[4:0]};
        n_flip = {n_sgn, 63'd0};
        n_sa   = n_a ^ n_flip;
        n_sb   = n_b ^ n_flip;
        unique case (n_op)
            tia_pkg::OP_ADD:  n_alt = n_a + n_b;
            tia_pkg::OP_SUB:  n_alt = n_a - n_b;
            tia_pkg::OP_AND:  n_alt = n_a & n_b;
            tia_pkg::OP_OR:   n_alt = n_a | n_b;
            tia_pkg::OP_XOR:  n_alt = n_a ^ n_b;
            tia_pkg::OP_SHL:  n_alt = n_big ? 64'd0 : (n_a << n_sh);
            tia_pkg::OP_SHR: begin
                if (n_sgn && n_a[63]) n_alt = n_big ? '1 : 64'($signed(n_a) >>> n_sh);
                else n_alt = n_big ? 64'd0 :
                    ((n_w64 ? n_a : {32'd0, n_a[31:0]}) >> n_sh);
            end
            tia_pkg::OP_EQ:   n_alt = {63'd0, n_a == n_b};
            tia_pkg::OP_NEQ:  n_alt = {63'd0, n_a != n_b};
            tia_pkg::OP_LT:   n_alt = {63'd0, n_sa < n_sb};
            tia_pkg::OP_GT:   n_alt = {63'd0, n_sa > n_sb};
            tia_pkg::OP_LTEQ: n_alt = {63'd0, n_sa <= n_sb};
            tia_pkg::OP_GTEQ: n_alt = {63'd0, n_sa >= n_sb};
            default:          n_alt = 64'd0;
        endcase
    end

    logic         r_d_valid;
    tia_pkg::t_op r_d_op;
    logic         r_d_tok, r_d_w64, r_d_sgn;
    logic [63:0]  r_d_a, r_d_b, r_d_alt, r_d_p0;
    logic [31:0]  r_d_p1, r_d_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= i_valid;
        end
        if (en) begin
            r_d_op  <= n_op;
            r_d_tok <= n_tok;
            r_d_w64 <= n_w64;
            r_d_sgn <= n_sgn;
            r_d_a   <= n_a;
            r_d_b   <= n_b;
            r_d_alt <= n_alt;
            r_d_p0  <= {32'd0, n_a[31:0]} * {32'd0, n_b[31:0]};
            r_d_p1  <= 32'(n_a[31:0] * n_b[63:32]);
            r_d_p2  <= 32'(n_a[63:32] * n_b[31:0]);
        end
    end

    // setup stage
    logic           s_valid [Cells+1];
    tia_pkg::t_ctrl s_ctrl  [Cells+1];
    logic [63:0]    s_den   [Cells+1];
    logic [63:0]    s_rem   [Cells+1];
    logic [63:0]    s_quo   [Cells+1];
    logic [63:0]    s_alt   [Cells+1];

    logic           n_s_divop;
    logic [31:0]    n_s_cross;
    tia_pkg::t_ctrl n_s_ctrl;

    always_comb begin
        n_s_divop      = r_d_op == tia_pkg::OP_DIV || r_d_op == tia_pkg::OP_MOD;
        n_s_cross      = r_d_p1 + r_d_p2;
        n_s_ctrl.op    = r_d_op;
        n_s_ctrl.w64   = r_d_w64;
        n_s_ctrl.sgn   = r_d_sgn;
        n_s_ctrl.tok   = r_d_tok;
        n_s_ctrl.fault = r_d_tok && n_s_divop && r_d_b == 64'd0;
        n_s_ctrl.negq  = r_d_sgn && (r_d_a[63] ^ r_d_b[63]);
        n_s_ctrl.negr  = r_d_sgn && r_d_a[63];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid[0] <= 1'b0;
        end else if (en) begin
            s_valid[0] <= r_d_valid;
        end
        if (en) begin
            s_ctrl[0] <= n_s_ctrl;
            s_den[0]  <= (r_d_sgn && r_d_b[63]) ? -r_d_b : r_d_b;
            s_quo[0]  <= (r_d_sgn && r_d_a[63]) ? -r_d_a : r_d_a;
            s_rem[0]  <= 64'd0;
            s_alt[0]  <= (r_d_op == tia_pkg::OP_MUL) ? r_d_p0 + {n_s_cross, 32'd0} : r_d_alt;
        end
    end

    for (genvar g = 0; g < Cells; g++) begin : g_cell
        tia_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[g]),
            .i_ctrl  (s_ctrl[g]),
            .i_den   (s_den[g]),
            .i_rem   (s_rem[g]),
            .i_quo   (s_quo[g]),
            .i_alt   (s_alt[g]),
            .o_valid (s_valid[g+1]),
            .o_ctrl  (s_ctrl[g+1]),
            .o_den   (s_den[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_quo   (s_quo[g+1]),
            .o_alt   (s_alt[g+1])
        );
    end

    // output stage
    tia_pkg::t_ctrl n_o_c;
    logic [63:0]    n_o_raw;
    logic [63:0]    n_o_res;

    always_comb begin
        n_o_c = s_ctrl[Cells];
        unique case (n_o_c.op)
            tia_pkg::OP_DIV: n_o_raw = n_o_c.negq ? -s_quo[Cells] : s_quo[Cells];
            tia_pkg::OP_MOD: n_o_raw = n_o_c.negr ? -s_rem[Cells] : s_rem[Cells];
            default:         n_o_raw = s_alt[Cells];
        endcase
        if (!n_o_c.tok || n_o_c.fault) n_o_res = 64'd0;
        else if (n_o_c.op == tia_pkg::OP_EQ || n_o_c.op == tia_pkg::OP_NEQ ||
                 n_o_c.op == tia_pkg::OP_LT || n_o_c.op == tia_pkg::OP_GT ||
                 n_o_c.op == tia_pkg::OP_LTEQ || n_o_c.op == tia_pkg::OP_GTEQ)
            n_o_res = n_o_raw;
        else n_o_res = tia_pkg::fit_word(n_o_raw, n_o_c.w64 ? 2'd3 : 2'd2, n_o_c.sgn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= s_valid[Cells];
        end
        if (en) begin
            o_result_value <= n_o_res;
            o_divide_fault <= n_o_c.fault;
        end
    end

    `TIA_ASSERT_NOW(a_fault_zero, o_valid && o_divide_fault, o_result_value == 64'd0, "fault with nonzero result")
    `TIA_ASSERT_NOW(a_fault_divop, s_valid[0] && s_ctrl[0].fault, s_ctrl[0].op == tia_pkg::OP_DIV || s_ctrl[0].op == tia_pkg::OP_MOD, "fault on non-divide op")
    `TIA_ASSERT_NEXT(a_chain_hold, !en && s_valid[Cells], s_valid[Cells] && $stable(s_quo[Cells]), "divider chain moved during stall")

endmodule
`default_nettype wire
